/* sv/spq_pkg.sv */
package spq_pkg;

    // queue depth, one entry per cell
    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // status codes
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_REMOVED  = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // one stored entry with its occupancy flag
    typedef struct packed {
        logic        valid;
        logic [31:0] id;
        logic [2:0]  pri;
        logic [31:0] stamp;
    } t_slot;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

/* sv/spq_if.sv */
// request channel
interface spq_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] entry_id;
    logic [2:0]  priority_code;

    modport source (output valid, cmd, entry_id, priority_code, input ready);
    modport sink   (input valid, cmd, entry_id, priority_code, output ready);
endinterface

// response channel
interface spq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] out_id;
    logic [2:0]  out_priority;
    logic [31:0] out_stamp;

    modport source (output valid, status, out_id, out_priority, out_stamp, input ready);
    modport sink   (input valid, status, out_id, out_priority, out_stamp, output ready);
endinterface

/* sv/spq_cell.sv */
module spq_cell
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_slot     i_new,
    input  t_slot     i_left,
    input  logic      i_left_behind,
    input  t_slot     i_right,
    output t_slot     o_slot,
    output logic      o_behind
);

    t_slot r_slot;
    t_slot n_slot;

    // new entry sorts ahead of this one: strictly smaller code, or cell empty
    assign o_behind = !r_slot.valid || (i_new.pri < r_slot.pri);

    // insert shifts the tail right, remove shifts everything left
    always_comb begin
        n_slot = r_slot;
        if (i_ctl.rem) begin
            n_slot = i_right;
        end else if (i_ctl.ins && o_behind) begin
            if (i_left_behind) begin
                n_slot = i_left;
            end else begin
                n_slot = i_new;
            end
        end
    end

    // occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot.valid <= n_slot.valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_slot.id    <= n_slot.id;
        r_slot.pri   <= n_slot.pri;
        r_slot.stamp <= n_slot.stamp;
    end

    assign o_slot = r_slot;

endmodule

/* sv/stable_priority_queue.sv */
// channel   dir   modport  words
// i_in      in    sink     cmd, entry_id, priority_code
// o_out     out   source   status, out_id, out_priority, out_stamp
//
// the sorted cell chain updates in the cycle a word is accepted
// and the response is registered, so one word per cycle is sustained while responses are taken
// the head cell always holds the entry to remove; inserts slot in behind equal codes
// synchronous active-low reset empties the chain and clears the arrival counter
// a stalled response blocks new words only while the output register stays full
module stable_priority_queue
    import spq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    spq_in_if.sink      i_in,
    spq_out_if.source   o_out
);

    t_slot      w_slot   [CAPACITY];
    logic       w_behind [CAPACITY];
    t_slot      w_new;
    t_cell_ctl  w_ctl;
    logic       w_accept;
    logic       w_full;
    logic       w_empty;

    logic [31:0]      r_stamp;
    logic [CNT_W-1:0] r_count;
    logic             r_out_valid;
    logic [1:0]       r_status;
    logic [31:0]      r_out_id;
    logic [2:0]       r_out_pri;
    logic [31:0]      r_out_stamp;

    // input handshake, output register frees as it drains
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = !w_slot[0].valid;

    assign w_ctl.ins = w_accept && (i_in.cmd == CMD_INSERT) && !w_full;
    assign w_ctl.rem = w_accept && (i_in.cmd == CMD_REMOVE) && !w_empty;

    assign w_new.valid = 1'b1;
    assign w_new.id    = i_in.entry_id;
    assign w_new.pri   = i_in.priority_code;
    assign w_new.stamp = r_stamp;

    // sorted chain of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_slot w_left;
        t_slot w_right;
        logic  w_left_behind;

        if (g == 0) begin : g_head
            assign w_left        = '0;
            assign w_left_behind = 1'b0;
        end else begin : g_mid
            assign w_left        = w_slot[g-1];
            assign w_left_behind = w_behind[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_slot[g+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_new         (w_new),
            .i_left        (w_left),
            .i_left_behind (w_left_behind),
            .i_right       (w_right),
            .o_slot        (w_slot[g]),
            .o_behind      (w_behind[g])
        );
    end

    // arrival counter and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp <= '0;
            r_count <= '0;
        end else if (w_ctl.ins) begin
            r_stamp <= r_stamp + 32'd1;
            r_count <= r_count + CNT_W'(1);
        end else if (w_ctl.rem) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    // response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // response payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (w_ctl.ins) begin
                r_status    <= ST_INSERTED;
                r_out_id    <= '0;
                r_out_pri   <= '0;
                r_out_stamp <= r_stamp;
            end else if (w_ctl.rem) begin
                r_status    <= ST_REMOVED;
                r_out_id    <= w_slot[0].id;
                r_out_pri   <= w_slot[0].pri;
                r_out_stamp <= w_slot[0].stamp;
            end else begin
                r_status    <= (i_in.cmd == CMD_INSERT) ? ST_FULL : ST_EMPTY;
                r_out_id    <= '0;
                r_out_pri   <= '0;
                r_out_stamp <= '0;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_status;
    assign o_out.out_id       = r_out_id;
    assign o_out.out_priority = r_out_pri;
    assign o_out.out_stamp    = r_out_stamp;

endmodule

/* sv/spq_chk.sv */
module spq_chk
    import spq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_out_status,
    input logic [31:0] i_out_id,
    input logic [2:0]  i_out_priority,
    input logic [31:0] i_out_stamp
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && i_in_ready;

    // stalled response holds its word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status)
            && $stable(i_out_id) && $stable(i_out_priority) && $stable(i_out_stamp))
        else $error("response changed while stalled");

    // every accepted word produces a response next cycle
    a_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> i_out_valid)
        else $error("accepted word without response");

    // no response appears without a request
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_acc && (!i_out_valid || i_out_ready) |=> !i_out_valid)
        else $error("response without request");

    // only removals carry an id and code
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != ST_REMOVED)
            |-> (i_out_id == 32'd0) && (i_out_priority == 3'd0))
        else $error("non-remove response carries entry data");

endmodule

bind stable_priority_queue spq_chk u_spq_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_status   (o_out.status),
    .i_out_id       (o_out.out_id),
    .i_out_priority (o_out.out_priority),
    .i_out_stamp    (o_out.out_stamp)
);
